// ===== rtl/qpn_pkg.sv =====
// Package for the normalized quaternion product block.
// Holds the format constants, the Hamilton sign table and the shared
// item types. It depends on nothing else.
`timescale 1ns / 1ps

package qpn_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRAC_BITS      = COMPONENT_BITS - 2;
  localparam int PROD_BITS      = 2 * COMPONENT_BITS;
  localparam int SUM_BITS       = 2 * COMPONENT_BITS + 2;
  localparam int MAG_BITS       = 2 * COMPONENT_BITS + 1;
  // Reduced magnitudes stay below 2^31, so their squared sum fits 64 bits.
  localparam int RED_BITS       = 31;
  localparam int MSQ_BITS       = 2 * RED_BITS + 2;
  localparam int QUO_BITS       = 2 * COMPONENT_BITS - 1;
  localparam int ROOT_BITS      = COMPONENT_BITS;
  localparam int SHIFT_BITS     = $clog2(MAG_BITS);
  localparam int MID_DEPTH      = 4;
  localparam int MID_PTR        = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH      = 2;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;

  // One classified item: reduced component magnitudes with their signs.
  typedef struct packed {
    logic                         zero;
    logic [3:0]                   neg;
    logic [3:0][RED_BITS-1:0]     mag;
  } work_t;

  typedef struct packed {
    logic        zero;
    comp_t [3:0] comp;
  } result_t;

  // Component c of left*right sums left[k] * right[HAM_RI[c][k]],
  // subtracted where HAM_NEG is set.
  localparam logic [1:0] HAM_RI [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

// ===== rtl/qpn_front.sv =====
// Front part: multiplies, sums the Hamilton terms and block-reduces the
// four magnitudes into a classified work item. Uses qpn_pkg.
`timescale 1ns / 1ps

module qpn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enable_i,
  input  logic                 accept_i,
  input  qpn_pkg::comp_t       left_i  [4],
  input  qpn_pkg::comp_t       right_i [4],
  output logic                 wr_o,
  output qpn_pkg::work_t       work_o
);
  import qpn_pkg::*;

  logic                        a_valid_q, b_valid_q;
  logic signed [PROD_BITS-1:0] prod_q [4][4];
  logic [MAG_BITS-1:0]         mag_q  [4];
  logic [MAG_BITS-1:0]         mag_d  [4];
  logic [3:0]                  neg_q, neg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (enable_i) begin
      a_valid_q <= accept_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enable_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_q[c][k] <= PROD_BITS'(left_i[k]) * PROD_BITS'(right_i[HAM_RI[c][k]]);
        end
        mag_q[c] <= mag_d[c];
      end
      neg_q <= neg_d;
    end
  end

  // Exact signed sum of the four terms, split into sign and magnitude.
  always_comb begin
    logic signed [SUM_BITS-1:0] sum;
    for (int c = 0; c < 4; c++) begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
        if (HAM_NEG[c][k]) sum = sum - SUM_BITS'(prod_q[c][k]);
        else               sum = sum + SUM_BITS'(prod_q[c][k]);
      end
      neg_d[c] = sum[SUM_BITS-1];
      mag_d[c] = neg_d[c] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
    end
  end

  // The largest magnitude sets the shift that brings all below 2^31.
  always_comb begin
    logic [MAG_BITS-1:0]          orv;
    logic [SHIFT_BITS-1:0]        shift;
    logic [MAG_BITS+RED_BITS-1:0] ext;
    orv   = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
    shift = '0;
    for (int i = RED_BITS; i < MAG_BITS; i++) begin
      if (orv[i]) shift = SHIFT_BITS'(i - RED_BITS + 1);
    end
    for (int c = 0; c < 4; c++) begin
      ext            = {{RED_BITS{1'b0}}, mag_q[c]} >> shift;
      work_o.mag[c]  = ext[RED_BITS-1:0];
    end
    work_o.neg  = neg_q;
    work_o.zero = (orv == '0);
    wr_o        = b_valid_q & enable_i;
  end

endmodule

// ===== rtl/qpn_mid_queue.sv =====
// Short queue between the front and back parts of the product block.
// Holds classified work items. Uses qpn_pkg.
`timescale 1ns / 1ps

module qpn_mid_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  qpn_pkg::work_t  data_i,
  input  logic            rd_i,
  output qpn_pkg::work_t  data_o,
  output logic            nonempty_o,
  output logic            space_o
);
  import qpn_pkg::*;

  work_t              mem_q [MID_DEPTH];
  logic [MID_PTR-1:0] wptr_q, rptr_q;
  logic [MID_PTR:0]   cnt_q, cnt_d;

  always_comb begin
    unique case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= data_i;
  end

  assign data_o     = mem_q[rptr_q];
  assign nonempty_o = (cnt_q != '0);
  assign space_o    = (cnt_q != (MID_PTR+1)'(MID_DEPTH));

endmodule

// ===== rtl/qpn_back.sv =====
// Back part: squares, sums, divides bit by bit and takes a digit-by-digit
// square root to find the rounded unit-length components. Uses qpn_pkg.
`timescale 1ns / 1ps

module qpn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  qpn_pkg::work_t    work_i,
  output logic              take_o,
  input  logic              pop_i,
  output logic              empty_o,
  output qpn_pkg::result_t  result_o
);
  import qpn_pkg::*;

  typedef struct packed {
    logic                         zero;
    logic [3:0]                   neg;
    logic [MSQ_BITS-1:0]          m;
    logic [3:0][MSQ_BITS-1:0]     rem;
    logic [3:0][QUO_BITS-1:0]     quo;
  } div_t;

  typedef struct packed {
    logic                         zero;
    logic [3:0]                   neg;
    logic [3:0][QUO_BITS-1:0]     t;
    logic [3:0][ROOT_BITS+1:0]    rem;
    logic [3:0][ROOT_BITS-1:0]    root;
  } sqrt_t;

  logic                      be;
  logic                      v0_q, v1_q, v2_q;
  logic [QUO_BITS-1:0]       dv_q;
  logic [ROOT_BITS-1:0]      sv_q;
  work_t                     w0_q;
  logic                      zero1_q, zero2_q;
  logic [3:0]                neg1_q, neg2_q;
  logic [2*RED_BITS-1:0]     sq1_q [4];
  logic [2*RED_BITS-1:0]     sq2_q [4];
  logic [MSQ_BITS-1:0]       m2_q;
  div_t                      div_in [QUO_BITS];
  div_t                      div_d  [QUO_BITS];
  div_t                      div_q  [QUO_BITS];
  sqrt_t                     sqrt_in [ROOT_BITS];
  sqrt_t                     sqrt_d  [ROOT_BITS];
  sqrt_t                     sqrt_q  [ROOT_BITS];
  result_t                   res_d;
  result_t                   oq_q [OUT_DEPTH];
  logic                      owp_q, orp_q;
  logic [1:0]                ocnt_q;
  logic                      owr, ord;

  assign be     = (ocnt_q != 2'(OUT_DEPTH));
  assign take_o = be & avail_i;
  assign owr    = sv_q[ROOT_BITS-1] & be;
  assign ord    = pop_i & (ocnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      dv_q <= '0;
      sv_q <= '0;
    end else if (be) begin
      v0_q <= take_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      dv_q <= {dv_q[QUO_BITS-2:0], v2_q};
      sv_q <= {sv_q[ROOT_BITS-2:0], dv_q[QUO_BITS-1]};
    end
  end

  // Restoring division: quotient is floor(r^2 * 2^(2F+2) / M).
  always_comb begin
    logic [MSQ_BITS:0] x;
    div_in[0].zero = zero2_q;
    div_in[0].neg  = neg2_q;
    div_in[0].m    = m2_q;
    for (int c = 0; c < 4; c++) begin
      div_in[0].rem[c] = MSQ_BITS'(sq2_q[c]);
      div_in[0].quo[c] = '0;
    end
    for (int st = 1; st < QUO_BITS; st++) div_in[st] = div_q[st-1];
    for (int st = 0; st < QUO_BITS; st++) begin
      div_d[st] = div_in[st];
      for (int c = 0; c < 4; c++) begin
        if (st == 0) x = {1'b0, div_in[st].rem[c]};
        else         x = {div_in[st].rem[c], 1'b0};
        if (x >= {1'b0, div_in[st].m}) begin
          x                 = x - {1'b0, div_in[st].m};
          div_d[st].quo[c]  = {div_in[st].quo[c][QUO_BITS-2:0], 1'b1};
        end else begin
          div_d[st].quo[c]  = {div_in[st].quo[c][QUO_BITS-2:0], 1'b0};
        end
        div_d[st].rem[c] = x[MSQ_BITS-1:0];
      end
    end
  end

  // Integer square root, two radicand bits per stage.
  always_comb begin
    logic [2*ROOT_BITS-1:0] tpad;
    logic [ROOT_BITS+1:0]   x;
    logic [ROOT_BITS+1:0]   trial;
    sqrt_in[0].zero = div_q[QUO_BITS-1].zero;
    sqrt_in[0].neg  = div_q[QUO_BITS-1].neg;
    for (int c = 0; c < 4; c++) begin
      sqrt_in[0].t[c]    = div_q[QUO_BITS-1].quo[c];
      sqrt_in[0].rem[c]  = '0;
      sqrt_in[0].root[c] = '0;
    end
    for (int j = 1; j < ROOT_BITS; j++) sqrt_in[j] = sqrt_q[j-1];
    for (int j = 0; j < ROOT_BITS; j++) begin
      sqrt_d[j] = sqrt_in[j];
      for (int c = 0; c < 4; c++) begin
        tpad  = {1'b0, sqrt_in[j].t[c]};
        x     = {sqrt_in[j].rem[c][ROOT_BITS-1:0], tpad[2*(ROOT_BITS-1-j) +: 2]};
        trial = {sqrt_in[j].root[c], 2'b01};
        if (x >= trial) begin
          sqrt_d[j].rem[c]  = x - trial;
          sqrt_d[j].root[c] = {sqrt_in[j].root[c][ROOT_BITS-2:0], 1'b1};
        end else begin
          sqrt_d[j].rem[c]  = x;
          sqrt_d[j].root[c] = {sqrt_in[j].root[c][ROOT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // The largest odd number whose square fits under the quotient is 2q-1.
  always_comb begin
    logic [ROOT_BITS:0]   up;
    logic [ROOT_BITS-1:0] q;
    res_d.zero = sqrt_q[ROOT_BITS-1].zero;
    for (int c = 0; c < 4; c++) begin
      up = {1'b0, sqrt_q[ROOT_BITS-1].root[c]} + (ROOT_BITS+1)'(1);
      q  = up[ROOT_BITS:1];
      if (sqrt_q[ROOT_BITS-1].zero)        res_d.comp[c] = '0;
      else if (sqrt_q[ROOT_BITS-1].neg[c]) res_d.comp[c] = comp_t'(-q);
      else                                 res_d.comp[c] = comp_t'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      w0_q    <= work_i;
      zero1_q <= w0_q.zero;
      neg1_q  <= w0_q.neg;
      for (int c = 0; c < 4; c++) begin
        sq1_q[c] <= (2*RED_BITS)'(w0_q.mag[c]) * (2*RED_BITS)'(w0_q.mag[c]);
        sq2_q[c] <= sq1_q[c];
      end
      zero2_q <= zero1_q;
      neg2_q  <= neg1_q;
      m2_q    <= MSQ_BITS'(sq1_q[0]) + MSQ_BITS'(sq1_q[1])
               + MSQ_BITS'(sq1_q[2]) + MSQ_BITS'(sq1_q[3]);
      div_q   <= div_d;
      sqrt_q  <= sqrt_d;
    end
    if (owr) oq_q[owp_q] <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (owr) owp_q <= ~owp_q;
      if (ord) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + {1'b0, owr} - {1'b0, ord};
    end
  end

  assign empty_o  = (ocnt_q == 2'd0);
  assign result_o = oq_q[orp_q];

endmodule

// ===== rtl/quaternion_product_normalize.sv =====
// Top level of the normalized quaternion product block.
// Joins qpn_front, qpn_mid_queue and qpn_back; uses qpn_pkg.
//
//  channel   handshake        payload
//  -------   ---------------  ------------------------------------------
//  input     push / full      left_{w,x,y,z}_i, right_{w,x,y,z}_i
//  result    pop / empty      out_{w,x,y,z}_o, zero_product_o
//
// One request is taken every cycle while full is low, and one result leaves
// every cycle while empty is low and pop is high. From acceptance to a
// result showing, an item passes the front part, the middle queue, and the
// back part's one-bit-per-stage divider and two-bits-per-stage square root.
// Reset clears all valid bits, pointers and counts; payload is not reset.
// A stalled result side fills the two-entry result queue, freezes the back
// pipeline, then fills the four-entry middle queue, and only then full rises.
`timescale 1ns / 1ps

module quaternion_product_normalize (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  qpn_pkg::comp_t  left_w_i,
  input  qpn_pkg::comp_t  left_x_i,
  input  qpn_pkg::comp_t  left_y_i,
  input  qpn_pkg::comp_t  left_z_i,
  input  qpn_pkg::comp_t  right_w_i,
  input  qpn_pkg::comp_t  right_x_i,
  input  qpn_pkg::comp_t  right_y_i,
  input  qpn_pkg::comp_t  right_z_i,
  output logic            empty,
  input  logic            pop,
  output qpn_pkg::comp_t  out_w_o,
  output qpn_pkg::comp_t  out_x_o,
  output qpn_pkg::comp_t  out_y_o,
  output qpn_pkg::comp_t  out_z_o,
  output logic            zero_product_o
);
  import qpn_pkg::*;

  comp_t   left  [4];
  comp_t   right [4];
  logic    space, wr, take, avail;
  work_t   front_work, mid_work;
  result_t result;

  // Components are indexed scalar, i, j, k.
  assign left[0]  = left_w_i;
  assign left[1]  = left_x_i;
  assign left[2]  = left_y_i;
  assign left[3]  = left_z_i;
  assign right[0] = right_w_i;
  assign right[1] = right_x_i;
  assign right[2] = right_y_i;
  assign right[3] = right_z_i;

  // The front advances only while the middle queue has a free slot, so an
  // item leaving the front always has a place to land.
  assign full = ~space;

  qpn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (space),
    .accept_i (push & space),
    .left_i   (left),
    .right_i  (right),
    .wr_o     (wr),
    .work_o   (front_work)
  );

  qpn_mid_queue u_mid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .data_i     (front_work),
    .rd_i       (take),
    .data_o     (mid_work),
    .nonempty_o (avail),
    .space_o    (space)
  );

  qpn_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (avail),
    .work_i   (mid_work),
    .take_o   (take),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result)
  );

  assign out_w_o        = result.comp[0];
  assign out_x_o        = result.comp[1];
  assign out_y_o        = result.comp[2];
  assign out_z_o        = result.comp[3];
  assign zero_product_o = result.zero;

endmodule

// ===== rtl/qpn_checker.sv =====
// Port-level checks for the normalized quaternion product block, bound to
// the top level. Uses qpn_pkg.
`timescale 1ns / 1ps

module qpn_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input qpn_pkg::comp_t  out_w_o,
  input qpn_pkg::comp_t  out_x_o,
  input qpn_pkg::comp_t  out_y_o,
  input qpn_pkg::comp_t  out_z_o,
  input logic            zero_product_o
);
  import qpn_pkg::*;

  localparam int Unit = 2 ** FRAC_BITS;
  localparam int Low  = Unit / 4;

  function automatic logic in_unit(comp_t v);
    return (int'(v) >= -Unit) && (int'(v) <= Unit);
  endfunction

  function automatic logic big(comp_t v);
    return (int'(v) >= Low) || (int'(v) <= -Low);
  endfunction

  // A waiting result neither vanishes nor changes until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_w_o) && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o) && $stable(zero_product_o))
    else $error("result changed while waiting");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && zero_product_o |->
      out_w_o == '0 && out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("zero product with nonzero components");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> in_unit(out_w_o) && in_unit(out_x_o)
      && in_unit(out_y_o) && in_unit(out_z_o))
    else $error("component beyond unit length");

  // A unit quaternion has a component of half length or more; the check asks for a quarter.
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !zero_product_o |->
      big(out_w_o) || big(out_x_o) || big(out_y_o) || big(out_z_o))
    else $error("nonzero product came out too short");

endmodule

bind quaternion_product_normalize qpn_checker u_qpn_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for quaternion_product_normalize.
// Holds a product/normalize predictor inside a small scoreboard class; uses qpn_pkg.
`timescale 1ns / 1ps

module tb_top;
  import qpn_pkg::*;

  typedef struct {
    comp_t lq[4];
    comp_t rq[4];
  } quat_pair_t;

  typedef struct {
    comp_t comp[4];
    logic  zero;
  } unit_prod_t;

  // Holds the normalized products that are still owed by the block.
  class product_board;
    unit_prod_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned zeros_seen;

    // Largest q in [0, 2^F] with (2q-1)^2 * msum <= r^2 * 2^(2F+2), so that
    // q is 2^F * r / sqrt(msum) rounded half away from zero.
    function automatic logic [15:0] round_norm(longint unsigned r, longint unsigned msum);
      logic [127:0] lhs;
      logic [127:0] rhs;
      longint unsigned q;
      longint unsigned cand;
      longint unsigned odd;
      q = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        if (cand <= (64'd1 << FRAC_BITS)) begin
          odd = 2 * cand - 1;
          lhs = 128'(odd * odd) * 128'(msum);
          rhs = (128'(r) * 128'(r)) << (2 * FRAC_BITS + 2);
          if (lhs <= rhs) begin
            q = cand;
          end
        end
      end
      return q[15:0];
    endfunction

    function automatic void note_request(quat_pair_t qp);
      longint p[4];
      longint a[4];
      longint b[4];
      longint unsigned mag[4];
      longint unsigned maxm;
      longint unsigned red[4];
      longint unsigned msum;
      int s;
      unit_prod_t e;
      logic [15:0] q;
      for (int i = 0; i < 4; i++) begin
        a[i] = qp.lq[i];
        b[i] = qp.rq[i];
      end
      // Standard Hamilton product left*right, exact.
      p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
      p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
      p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
      p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
      maxm = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = (p[i] < 0) ? -p[i] : p[i];
        if (mag[i] > maxm) maxm = mag[i];
      end
      e.zero = (maxm == 0);
      if (e.zero) begin
        for (int i = 0; i < 4; i++) e.comp[i] = '0;
      end else begin
        s = 0;
        while ((maxm >> s) >= (64'd1 << 31)) s++;
        msum = 0;
        for (int i = 0; i < 4; i++) begin
          red[i] = mag[i] >> s;
          msum += red[i] * red[i];
        end
        for (int i = 0; i < 4; i++) begin
          q = round_norm(red[i], msum);
          e.comp[i] = (p[i] < 0) ? -$signed(q) : $signed(q);
        end
      end
      pending.push_back(e);
    endfunction

    function automatic void check_result(unit_prod_t got);
      unit_prod_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (e.zero) zeros_seen++;
      if (got.zero !== e.zero || got.comp[0] !== e.comp[0] || got.comp[1] !== e.comp[1]
          || got.comp[2] !== e.comp[2] || got.comp[3] !== e.comp[3]) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected w=%0d x=%0d y=%0d z=%0d zero=%0b", checked,
                   e.comp[0], e.comp[1], e.comp[2], e.comp[3], e.zero);
          $display("       actual w=%0d x=%0d y=%0d z=%0d zero=%0b",
                   got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.zero);
        end
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  push;
  logic  full;
  logic  empty;
  logic  pop;
  comp_t lq_d[4];
  comp_t rq_d[4];
  comp_t out_w_o, out_x_o, out_y_o, out_z_o;
  logic  zero_product_o;

  product_board board;
  bit          quiet_tail;  // no idling on either side in the last stretch
  int          sent;

  quaternion_product_normalize dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .left_w_i       (lq_d[0]),
    .left_x_i       (lq_d[1]),
    .left_y_i       (lq_d[2]),
    .left_z_i       (lq_d[3]),
    .right_w_i      (rq_d[0]),
    .right_x_i      (rq_d[1]),
    .right_y_i      (rq_d[2]),
    .right_z_i      (rq_d[3]),
    .empty          (empty),
    .pop            (pop),
    .out_w_o        (out_w_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .zero_product_o (zero_product_o)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Monitor: the values read here are the ones present before the edge,
  // since all drivers update through nonblocking assignments.
  always @(posedge clk_i) begin
    unit_prod_t got;
    quat_pair_t qp;
    if (rst_ni) begin
      if (push && !full) begin
        qp.lq = lq_d;
        qp.rq = rq_d;
        board.note_request(qp);
      end
      if (pop && !empty) begin
        got.comp[0] = out_w_o;
        got.comp[1] = out_x_o;
        got.comp[2] = out_y_o;
        got.comp[3] = out_z_o;
        got.zero    = zero_product_o;
        board.check_result(got);
      end
    end
  end

  // Result side: pop high most of the time, with random stall bursts.
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Presents one request and holds it until the block takes it. The caller
  // decides whether push stays high for the next one or drops for a gap.
  task automatic send_request(quat_pair_t qp);
    push <= 1'b1;
    lq_d <= qp.lq;
    rq_d <= qp.rq;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
      2: return $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
      default: return $urandom_range(0, 3) == 0 ? comp_t'(0) : comp_t'($urandom);
    endcase
  endfunction

  function automatic quat_pair_t make_pair(int l0, int l1, int l2, int l3,
                                           int r0, int r1, int r2, int r3);
    quat_pair_t qp;
    qp.lq = '{comp_t'(l0), comp_t'(l1), comp_t'(l2), comp_t'(l3)};
    qp.rq = '{comp_t'(r0), comp_t'(r1), comp_t'(r2), comp_t'(r3)};
    return qp;
  endfunction

  // Main stimulus.
  initial begin
    quat_pair_t directed[$];
    quat_pair_t qp;
    int one;
    int mode;
    board = new();
    quiet_tail = 1'b0;
    sent = 0;
    push <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      lq_d[i] <= '0;
      rq_d[i] <= '0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    one = 16384;
    // Directed part: zero products, identities, basis units, extremes.
    directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_pair(0, 0, 0, 0, 1234, -77, 32767, -32768));
    directed.push_back(make_pair(-32768, 5, 9, 1, 0, 0, 0, 0));
    directed.push_back(make_pair(one, 0, 0, 0, one, 0, 0, 0));
    directed.push_back(make_pair(0, one, 0, 0, 0, one, 0, 0));
    directed.push_back(make_pair(0, 0, one, 0, 0, 0, one, 0));
    directed.push_back(make_pair(0, 0, 0, one, 0, 0, 0, one));
    directed.push_back(make_pair(0, one, 0, 0, 0, 0, one, 0));
    directed.push_back(make_pair(0, 0, one, 0, 0, one, 0, 0));
    directed.push_back(make_pair(0, 0, one, 0, 0, 0, 0, one));
    directed.push_back(make_pair(0, 0, 0, one, 0, one, 0, 0));
    directed.push_back(make_pair(-32768, -32768, -32768, -32768,
                                 -32768, -32768, -32768, -32768));
    directed.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(make_pair(-32768, 32767, -32768, 32767,
                                 32767, -32768, 32767, -32768));
    directed.push_back(make_pair(-32768, 32767, 32767, 32767,
                                 -32768, -32768, -32768, -32768));
    directed.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0));
    directed.push_back(make_pair(-1, 1, -1, 1, 1, 1, 1, -1));
    directed.push_back(make_pair(3, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_pair(11585, 11585, 0, 0, 11585, 0, 11585, 0));
    foreach (directed[i]) begin
      send_request(directed[i]);
    end

    // Hold off until every outstanding product has come back.
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);

    for (int n = 0; n < 1100; n++) begin
      if (n == 950) quiet_tail = 1'b1;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        qp.lq[i] = rand_comp(mode);
        qp.rq[i] = rand_comp($urandom_range(0, 3));
      end
      // Now and then one whole operand is zero to hit the zero product.
      if ($urandom_range(0, 39) == 0) begin
        for (int i = 0; i < 4; i++) qp.rq[i] = '0;
      end
      send_request(qp);
      maybe_gap();
    end
    push <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results, %0d of them zero products.",
             sent, board.checked, board.zeros_seen);
    $display("Mismatches: %0d.", board.errors);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("Timeout waiting for the block.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
